// ----- sv/ata_pio_pkg.sv -----
// types, codes and constants of the ata pio lba28 sequencer
package ata_pio_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WPS_SHIFT = $clog2(WORDS_PER_SECTOR);
    localparam int REG_WRITES = 6;

    localparam logic [15:0] POLL_LIMIT_RESET = 16'd10000;
    localparam logic [8:0] BASE_PRIMARY = 9'h1f0;
    localparam logic [8:0] BASE_SECONDARY = 9'h170;
    localparam logic [7:0] DH_LBA_MODE = 8'h40;
    localparam logic [7:0] CMD_READ = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam int ST_BSY_BIT = 7;
    localparam int ST_DRQ_BIT = 3;

    localparam logic [2:0] REQ_READ = 3'd0;
    localparam logic [2:0] REQ_WRITE = 3'd1;
    localparam logic [2:0] REQ_STATUS = 3'd2;
    localparam logic [2:0] REQ_DRIVE_WORD = 3'd3;
    localparam logic [2:0] REQ_HOST_WORD = 3'd4;

    localparam logic [1:0] KIND_REG = 2'd0;
    localparam logic [1:0] KIND_DATA_OUT = 2'd1;
    localparam logic [1:0] KIND_DATA_IN = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_DRIVE = 2'd1;
    localparam logic [1:0] ERR_TIMEOUT = 2'd2;
    localparam logic [1:0] ERR_RANGE = 2'd3;

    localparam logic [2:0] OFS_DATA = 3'd0;
    localparam logic [2:0] OFS_COUNT = 3'd2;
    localparam logic [2:0] OFS_LBA_LO = 3'd3;
    localparam logic [2:0] OFS_LBA_MID = 3'd4;
    localparam logic [2:0] OFS_LBA_HI = 3'd5;
    localparam logic [2:0] OFS_DRIVE_HEAD = 3'd6;
    localparam logic [2:0] OFS_COMMAND = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WAIT_BSY,
        PH_WAIT_DRQ,
        PH_XFER
    } phase_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  drive_id;
        logic [31:0] start_lba;
        logic [8:0]  sector_count;
        logic [7:0]  status_byte;
        logic [15:0] data_word;
    } req_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [8:0]  channel_base;
        logic [2:0]  reg_offset;
        logic [7:0]  reg_value;
        logic [15:0] out_word;
        logic [1:0]  error_code;
        logic        last;
    } res_t;

endpackage

// ----- sv/ata_pio_lba28_sequencer.sv -----
// top level of the ata pio lba28 host sequencer
//
// in channel: in_valid / in_stall carry requests (start read or write, status
// samples, data words from drive or host). out channel: out_valid / out_stall
// carry results (task-file register writes, data words, completions).
// a request is taken into the sequence state in the cycle of its transfer and
// its first result shows on the output register in the following cycle.
// a request causing at most one result is taken every cycle while the output
// side does not stall; a result waiting in the output register does not block
// the next request, the two move in the same cycle.
// the ready-for-command sample causes six register writes, shown one per cycle from
// the output register while out_stall is low; a data word ending the sector run
// causes the word and then the completion. in_stall stays high while more than the
// last of these remains, and also while one result waits and out_stall is high.
// out_stall holds the current result steady; nothing is lost.
// reset (rst_n low, asynchronous) returns to idle, empties the output register
// and sets poll_limit to 10000. cfg_we writes poll_limit from cfg_wdata.
module ata_pio_lba28_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ata_pio_pkg::req_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ata_pio_pkg::res_t   out_data,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata
);
    import ata_pio_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        is_write_reg, is_write_next;
    logic        secondary_reg, secondary_next;
    logic        slave_reg, slave_next;
    logic [27:0] lba_reg, lba_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] poll_cnt_reg, poll_cnt_next;
    logic [15:0] words_left_reg, words_left_next;
    logic [15:0] poll_limit_reg;
    logic [2:0]  pend_reg, pend_next;
    res_t        res_reg, res_next;

    logic        in_xfer;
    logic        out_take;
    logic [8:0]  base;
    logic [15:0] poll_inc;
    logic [15:0] words_dec;
    logic [2:0]  new_n;
    res_t        new_res;

    function automatic res_t done_res(input logic [8:0] b, input logic [1:0] err);
        res_t r;
        r = '0;
        r.out_kind = KIND_DONE;
        r.channel_base = b;
        r.error_code = err;
        return r;
    endfunction

    function automatic res_t reg_res(input logic [2:0] idx, input logic [8:0] b,
                                     input logic slave, input logic wr,
                                     input logic [27:0] lba, input logic [7:0] cnt);
        res_t r;
        r = '0;
        r.out_kind = KIND_REG;
        r.channel_base = b;
        case (idx)
            3'd0:
            begin
                r.reg_offset = OFS_DRIVE_HEAD;
                r.reg_value = DH_LBA_MODE | {3'b000, slave, lba[27:24]};
            end
            3'd1:
            begin
                r.reg_offset = OFS_COUNT;
                r.reg_value = cnt;
            end
            3'd2:
            begin
                r.reg_offset = OFS_LBA_LO;
                r.reg_value = lba[7:0];
            end
            3'd3:
            begin
                r.reg_offset = OFS_LBA_MID;
                r.reg_value = lba[15:8];
            end
            3'd4:
            begin
                r.reg_offset = OFS_LBA_HI;
                r.reg_value = lba[23:16];
            end
            default:
            begin
                r.reg_offset = OFS_COMMAND;
                r.reg_value = wr ? CMD_WRITE : CMD_READ;
            end
        endcase
        return r;
    endfunction

    assign out_valid = (pend_reg != 3'd0);
    assign out_data = res_reg;
    assign out_take = out_valid && !out_stall;
    assign in_stall = (pend_reg > 3'd1) || ((pend_reg == 3'd1) && out_stall);
    assign in_xfer = in_valid && !in_stall;
    assign base = secondary_reg ? BASE_SECONDARY : BASE_PRIMARY;
    assign poll_inc = poll_cnt_reg + 16'd1;
    assign words_dec = words_left_reg - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            is_write_reg <= 1'b0;
            secondary_reg <= 1'b0;
            slave_reg <= 1'b0;
            lba_reg <= '0;
            count_reg <= '0;
            poll_cnt_reg <= '0;
            words_left_reg <= '0;
            poll_limit_reg <= POLL_LIMIT_RESET;
            pend_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            is_write_reg <= is_write_next;
            secondary_reg <= secondary_next;
            slave_reg <= slave_next;
            lba_reg <= lba_next;
            count_reg <= count_next;
            poll_cnt_reg <= poll_cnt_next;
            words_left_reg <= words_left_next;
            pend_reg <= pend_next;
            if (cfg_we)
            begin
                poll_limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        is_write_next = is_write_reg;
        secondary_next = secondary_reg;
        slave_next = slave_reg;
        lba_next = lba_reg;
        count_next = count_reg;
        poll_cnt_next = poll_cnt_reg;
        words_left_next = words_left_reg;
        new_n = 3'd0;
        new_res = '0;

        if (in_xfer)
        begin
            case (in_data.req_type)
                REQ_READ, REQ_WRITE:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        if (in_data.drive_id > 4'd3)
                        begin
                            new_res = done_res(9'd0, ERR_DRIVE);
                            new_n = 3'd1;
                        end
                        else if ((in_data.start_lba[31:28] != 4'd0) ||
                                 in_data.sector_count[8])
                        begin
                            new_res = done_res(9'd0, ERR_RANGE);
                            new_n = 3'd1;
                        end
                        else
                        begin
                            is_write_next = (in_data.req_type == REQ_WRITE);
                            secondary_next = in_data.drive_id[1];
                            slave_next = in_data.drive_id[0];
                            lba_next = in_data.start_lba[27:0];
                            count_next = in_data.sector_count[7:0];
                            poll_cnt_next = '0;
                            words_left_next = '0;
                            phase_next = PH_WAIT_BSY;
                        end
                    end
                end
                REQ_STATUS:
                begin
                    if (phase_reg == PH_WAIT_BSY)
                    begin
                        if (!in_data.status_byte[ST_BSY_BIT])
                        begin
                            new_res = reg_res(3'd0, base, slave_reg, is_write_reg,
                                              lba_reg, count_reg);
                            new_n = 3'(REG_WRITES);
                            poll_cnt_next = '0;
                            phase_next = PH_WAIT_DRQ;
                        end
                        else
                        begin
                            poll_cnt_next = poll_inc;
                            if (poll_inc >= poll_limit_reg)
                            begin
                                new_res = done_res(base, ERR_TIMEOUT);
                                new_n = 3'd1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    else if (phase_reg == PH_WAIT_DRQ)
                    begin
                        if (!in_data.status_byte[ST_BSY_BIT] &&
                            in_data.status_byte[ST_DRQ_BIT])
                        begin
                            words_left_next = 16'(count_reg) << WPS_SHIFT;
                            if (count_reg == 8'd0)
                            begin
                                new_res = done_res(base, ERR_OK);
                                new_n = 3'd1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_XFER;
                            end
                        end
                        else
                        begin
                            poll_cnt_next = poll_inc;
                            if (poll_inc >= poll_limit_reg)
                            begin
                                new_res = done_res(base, ERR_TIMEOUT);
                                new_n = 3'd1;
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                REQ_DRIVE_WORD, REQ_HOST_WORD:
                begin
                    if ((phase_reg == PH_XFER) &&
                        ((in_data.req_type == REQ_HOST_WORD) == is_write_reg))
                    begin
                        new_res = '0;
                        new_res.out_kind = is_write_reg ? KIND_DATA_OUT : KIND_DATA_IN;
                        new_res.channel_base = base;
                        new_res.reg_offset = OFS_DATA;
                        new_res.out_word = in_data.data_word;
                        new_n = 3'd1;
                        words_left_next = words_dec;
                        if (words_dec == 16'd0)
                        begin
                            new_n = 3'd2;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // output register: a new burst replaces the finished one
        res_next = res_reg;
        pend_next = pend_reg;
        if (new_n != 3'd0)
        begin
            res_next = new_res;
            res_next.last = (new_n == 3'd1);
            pend_next = new_n;
        end
        else if (out_take)
        begin
            pend_next = pend_reg - 3'd1;
            if (pend_reg > 3'd1)
            begin
                if (res_reg.out_kind == KIND_REG)
                begin
                    res_next = reg_res(3'(REG_WRITES) + 3'd1 - pend_reg, base, slave_reg,
                                       is_write_reg, lba_reg, count_reg);
                end
                else
                begin
                    res_next = done_res(base, ERR_OK);
                end
                res_next.last = (pend_reg == 3'd2);
            end
        end
    end

endmodule
